### rtl/core/mpsd_pkg.sv
// Shared types and constants for the motion page stream decoder.
// Used by mpsd_ctrl, mpsd_dp and the top level; depends on nothing.
package mpsd_pkg;

    // Page geometry
    localparam int JOINTS = 18;
    localparam int GROUPS = JOINTS / 3;
    localparam int BP_W   = 5;
    localparam int GRP_W  = 4;

    // Header byte positions that carry state, and the last byte of a position word
    localparam logic [BP_W-1:0] HEAD_RATE  = BP_W'(3);
    localparam logic [BP_W-1:0] HEAD_STEPS = BP_W'(5);
    localparam logic [BP_W-1:0] WORD_LAST  = BP_W'(3);

    // Position and time arithmetic
    localparam int          POS_W      = 10;
    localparam int          POS_SHIFT  = 11;
    localparam logic [15:0] TIME_LIMIT = 16'd6500;
    localparam logic [15:0] TIME_SCALE = 16'd10;
    localparam int          DIV_W      = 16;

    typedef enum logic [3:0] {
        KIND_FLEX    = 4'd0,
        KIND_NEXT    = 4'd1,
        KIND_EXIT    = 4'd2,
        KIND_REPEAT  = 4'd3,
        KIND_RATE    = 4'd4,
        KIND_INERTIA = 4'd5,
        KIND_STEPS   = 4'd6,
        KIND_POS     = 4'd7,
        KIND_PAUSE   = 4'd8,
        KIND_PLAY    = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        VS_BYTE = 3'd0,
        VS_POS0 = 3'd1,
        VS_POS1 = 3'd2,
        VS_POS2 = 3'd3,
        VS_TIME = 3'd4
    } val_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic        ld_out;
        val_sel_t    val_sel;
        kind_t       kind;
        logic [7:0]  step;
        logic [4:0]  joint;
        logic        done;
        logic        asm_wr;
        logic [1:0]  asm_lane;
        logic        rate_wr;
        logic        div_start;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_busy;
    } dp_stat_t;

endpackage

### rtl/core/mpsd_ctrl.sv
// Controller for the motion page stream decoder: page section, byte, step and
// group counters, and the sequencing of multi-record items. Uses mpsd_pkg.
module mpsd_ctrl
    import mpsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_start,
    output ctrl_cmd_t  cmd,
    input  dp_stat_t   stat
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_POS1 = 4'b0010,
        ST_POS2 = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    typedef enum logic [5:0] {
        SEC_IDLE  = 6'b000001,
        SEC_FLEX  = 6'b000010,
        SEC_HEAD  = 6'b000100,
        SEC_POS   = 6'b001000,
        SEC_PAUSE = 6'b010000,
        SEC_PLAY  = 6'b100000
    } sec_t;

    state_t           st_reg, st_next;
    sec_t             sec_reg, sec_next;
    logic [BP_W-1:0]  bp_reg, bp_next;
    logic [7:0]       step_reg, step_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [7:0]       total_reg, total_next;

    sec_t             eff_sec;
    logic [BP_W-1:0]  eff_bp;
    logic [7:0]       eff_step;
    logic [GRP_W-1:0] eff_grp;
    logic [7:0]       eff_total;
    logic [4:0]       joint_base;
    logic             last_step;
    logic             accept;
    logic             head_done;

    assign s_ready    = (st_reg == ST_RUN) && stat.out_free;
    assign accept     = s_valid && s_ready;
    assign joint_base = 5'({grp_reg, 1'b0}) + 5'(grp_reg);
    assign last_step  = (9'(step_reg) + 9'd1) >= 9'(total_reg);
    assign head_done  = (s_byte == 8'd0);

    // A start mark restarts the page at this byte
    always_comb begin
        eff_sec   = s_start ? SEC_FLEX : sec_reg;
        eff_bp    = s_start ? '0 : bp_reg;
        eff_step  = s_start ? '0 : step_reg;
        eff_grp   = s_start ? '0 : grp_reg;
        eff_total = s_start ? '0 : total_reg;
    end

    // Sequence sections and records
    always_comb begin
        st_next    = st_reg;
        sec_next   = sec_reg;
        bp_next    = bp_reg;
        step_next  = step_reg;
        grp_next   = grp_reg;
        total_next = total_reg;
        cmd        = '0;
        cmd.val_sel = VS_BYTE;
        cmd.kind    = KIND_FLEX;
        cmd.step    = step_reg;

        case (st_reg)
            ST_RUN: begin
                if (accept) begin
                    sec_next   = eff_sec;
                    bp_next    = eff_bp;
                    step_next  = eff_step;
                    grp_next   = eff_grp;
                    total_next = eff_total;
                    case (eff_sec)
                        SEC_FLEX: begin
                            cmd.ld_out = 1'b1;
                            cmd.kind   = KIND_FLEX;
                            cmd.step   = '0;
                            cmd.joint  = 5'(eff_bp);
                            if (eff_bp == BP_W'(JOINTS - 1)) begin
                                sec_next = SEC_HEAD;
                                bp_next  = '0;
                            end else begin
                                bp_next = eff_bp + 1'b1;
                            end
                        end
                        SEC_HEAD: begin
                            cmd.ld_out  = 1'b1;
                            cmd.kind    = kind_t'(4'(KIND_NEXT) + 4'(eff_bp));
                            cmd.step    = '0;
                            cmd.rate_wr = (eff_bp == HEAD_RATE);
                            if (eff_bp == HEAD_STEPS) begin
                                cmd.done   = head_done;
                                total_next = s_byte;
                                sec_next   = head_done ? SEC_IDLE : SEC_POS;
                                bp_next    = '0;
                                step_next  = '0;
                                grp_next   = '0;
                            end else begin
                                bp_next = eff_bp + 1'b1;
                            end
                        end
                        SEC_POS: begin
                            if (eff_bp < WORD_LAST) begin
                                cmd.asm_wr   = 1'b1;
                                cmd.asm_lane = 2'(eff_bp);
                                bp_next      = eff_bp + 1'b1;
                            end else begin
                                cmd.ld_out  = 1'b1;
                                cmd.val_sel = VS_POS0;
                                cmd.kind    = KIND_POS;
                                cmd.joint   = joint_base;
                                bp_next     = '0;
                                st_next     = ST_POS1;
                            end
                        end
                        SEC_PAUSE, SEC_PLAY: begin
                            if (eff_bp == '0) begin
                                cmd.asm_wr   = 1'b1;
                                cmd.asm_lane = 2'd0;
                                bp_next      = BP_W'(1);
                            end else begin
                                cmd.div_start = 1'b1;
                                bp_next       = '0;
                                st_next       = ST_DIV;
                            end
                        end
                        default: begin
                            sec_next = SEC_IDLE;
                        end
                    endcase
                end
            end
            ST_POS1: begin
                cmd.val_sel = VS_POS1;
                cmd.kind    = KIND_POS;
                cmd.joint   = joint_base + 5'd1;
                if (stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    st_next    = ST_POS2;
                end
            end
            ST_POS2: begin
                cmd.val_sel = VS_POS2;
                cmd.kind    = KIND_POS;
                cmd.joint   = joint_base + 5'd2;
                if (stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    st_next    = ST_RUN;
                    // Advance group, then step, then section
                    if (grp_reg == GRP_W'(GROUPS - 1)) begin
                        grp_next = '0;
                        if (last_step) begin
                            step_next = '0;
                            sec_next  = SEC_PAUSE;
                        end else begin
                            step_next = step_reg + 8'd1;
                        end
                    end else begin
                        grp_next = grp_reg + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.val_sel = VS_TIME;
                cmd.kind    = (sec_reg == SEC_PLAY) ? KIND_PLAY : KIND_PAUSE;
                cmd.done    = (sec_reg == SEC_PLAY) && last_step;
                if (!stat.div_busy && stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    st_next    = ST_RUN;
                    if (last_step) begin
                        step_next = '0;
                        sec_next  = (sec_reg == SEC_PAUSE) ? SEC_PLAY : SEC_IDLE;
                    end else begin
                        step_next = step_reg + 8'd1;
                    end
                end
            end
            default: begin
                st_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_RUN;
            sec_reg   <= SEC_IDLE;
            bp_reg    <= '0;
            step_reg  <= '0;
            grp_reg   <= '0;
            total_reg <= '0;
        end else begin
            st_reg    <= st_next;
            sec_reg   <= sec_next;
            bp_reg    <= bp_next;
            step_reg  <= step_next;
            grp_reg   <= grp_next;
            total_reg <= total_next;
        end
    end

endmodule

### rtl/core/mpsd_dp.sv
// Datapath for the motion page stream decoder: word assembly, speed rate,
// bit-serial time divider and the result register. Uses mpsd_pkg.
module mpsd_dp
    import mpsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_byte,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic        m_ready,
    output logic        m_valid,
    output kind_t       m_kind,
    output logic [7:0]  m_step,
    output logic [4:0]  m_joint,
    output logic [15:0] m_value,
    output logic        m_sat,
    output logic        m_done
);

    logic [23:0] asm_reg;
    logic [7:0]  rate_reg;

    logic [DIV_W-1:0]         dq_reg;
    logic [7:0]               rem_reg;
    logic [$clog2(DIV_W)-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     long_reg;

    logic        valid_reg, valid_next;

    logic [15:0] t_word;
    logic        t_small;
    logic [8:0]  trial;
    logic        trial_ge;
    logic [19:0] prod;
    logic        t_sat;
    logic [15:0] t_val;
    logic [15:0] value;
    logic        sat;

    assign t_word   = {s_byte, asm_reg[7:0]};
    assign t_small  = (t_word != 16'd0) && (t_word < TIME_LIMIT);
    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, rate_reg};

    // Assemble word bytes and hold the speed rate
    always_ff @(posedge aclk) begin
        if (cmd.asm_wr) begin
            asm_reg[8*cmd.asm_lane +: 8] <= s_byte;
        end
        if (cmd.rate_wr) begin
            rate_reg <= s_byte;
        end
    end

    // Restoring divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dq_reg   <= t_small ? 16'(t_word * TIME_SCALE) : t_word;
            long_reg <= !t_small;
            rem_reg  <= '0;
            cnt_reg  <= '1;
        end else if (busy_reg) begin
            rem_reg <= trial_ge ? 8'(trial - {1'b0, rate_reg}) : trial[7:0];
            dq_reg  <= {dq_reg[DIV_W-2:0], trial_ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Scale the quotient and saturate
    always_comb begin
        prod  = 20'({dq_reg, 3'b000}) + 20'({dq_reg, 1'b0});
        t_sat = (rate_reg == 8'd0) || (long_reg && prod[19:16] != 4'd0);
        if (t_sat) begin
            t_val = 16'hFFFF;
        end else if (long_reg) begin
            t_val = prod[15:0];
        end else begin
            t_val = dq_reg;
        end
    end

    // Select the record value
    always_comb begin
        sat = 1'b0;
        case (cmd.val_sel)
            VS_BYTE: value = {8'd0, s_byte};
            VS_POS0: value = 16'({s_byte, asm_reg[23:22]});
            VS_POS1: value = 16'(asm_reg[2*POS_SHIFT-2 -: POS_W]);
            VS_POS2: value = 16'(asm_reg[POS_W-1:0]);
            VS_TIME: begin
                value = t_val;
                sat   = t_sat;
            end
            default: value = '0;
        endcase
    end

    // Result register
    always_comb begin
        valid_next = valid_reg;
        if (cmd.ld_out) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_kind  <= cmd.kind;
            m_step  <= cmd.step;
            m_joint <= cmd.joint;
            m_value <= value;
            m_sat   <= sat;
            m_done  <= cmd.done;
        end
    end

    assign m_valid       = valid_reg;
    assign stat.out_free = !valid_reg || m_ready;
    assign stat.div_busy = busy_reg;

endmodule

### rtl/core/motion_page_stream_decoder.sv
// Motion page stream decoder: one page byte per item in, tagged records out.
// A byte's first record is registered in the output register; the other two
// positions of a word follow from ST_POS1 and ST_POS2, and a time record is
// loaded when the divide ends. Throughput: one byte per cycle while the output
// is free; input stalls after a word's last byte and after a time's high byte.
// Synchronous active-low reset: idle section, empty output register.
module motion_page_stream_decoder
    import mpsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] page_byte
    input  logic        s_tuser,   // [0] start_of_page
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] step_number, [12:8] joint_number,
                                   // [28:13] field_value, [29] saturated
    output logic [3:0]  m_tuser,   // [3:0] record_kind
    output logic        m_tlast    // page_done
);

    ctrl_cmd_t   ctrl_cmd;
    dp_stat_t    dp_stat;
    kind_t       out_kind;
    logic [7:0]  out_step;
    logic [4:0]  out_joint;
    logic [15:0] out_value;
    logic        out_sat;

    mpsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_byte  (s_tdata),
        .s_start (s_tuser),
        .cmd     (ctrl_cmd),
        .stat    (dp_stat)
    );

    mpsd_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_byte  (s_tdata),
        .cmd     (ctrl_cmd),
        .stat    (dp_stat),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_kind  (out_kind),
        .m_step  (out_step),
        .m_joint (out_joint),
        .m_value (out_value),
        .m_sat   (out_sat),
        .m_done  (m_tlast)
    );

    assign m_tdata = {2'b00, out_sat, out_value, out_joint, out_step};
    assign m_tuser = out_kind;

`ifndef SYNTHESIS
    // No byte is taken while a time is being divided
    a_no_accept_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.div_busy |-> !s_tready)
        else $error("input accepted during divide");

    // Saturation only marks time records
    a_sat_time_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[29]) |->
            (m_tuser == KIND_PAUSE || m_tuser == KIND_PLAY))
        else $error("saturated flag on a non-time record");

    // The page ends on the steps record or a play record
    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (m_tuser == KIND_STEPS || m_tuser == KIND_PLAY))
        else $error("page_done on an unexpected record");
`endif

endmodule
